// File: rtl/mpp_pkg.sv
// Package for the motor power to pulse width core: field widths, register
// indexes, reset values, region codes and pipeline payload types.
// No dependencies.
package mpp_pkg;

  // Field and datapath widths
  localparam int unsigned CMD_W   = 13;  // power command and signed registers
  localparam int unsigned PCFG_W  = 12;  // pulse and dead band registers
  localparam int unsigned DIFF_W  = 14;  // command minus range end
  localparam int unsigned DQ_W    = 13;  // pulse span, signed
  localparam int unsigned PROD_W  = 26;  // product, magnitude below 2^25
  localparam int unsigned MAG_W   = 25;  // product magnitude, quotient width
  localparam int unsigned DEN_W   = 13;  // input span magnitude
  localparam int unsigned REM_W   = 14;  // partial remainder, one bit above DEN_W
  localparam int unsigned VAL_W   = 27;  // signed result before saturation

  // Configuration port
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_NEUTRAL_POINT = 3'd0;
  localparam logic [IDX_W-1:0] REG_DEAD_BAND     = 3'd1;
  localparam logic [IDX_W-1:0] REG_TOP_INPUT     = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOTTOM_INPUT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_PULSE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_NEUTRAL_PULSE = 3'd5;
  localparam logic [IDX_W-1:0] REG_MIN_PULSE     = 3'd6;

  // Reset values
  localparam logic signed [CMD_W-1:0] RST_NEUTRAL_POINT = 13'sd0;
  localparam logic [PCFG_W-1:0]       RST_DEAD_BAND     = 12'd0;
  localparam logic signed [CMD_W-1:0] RST_TOP_INPUT     = 13'sd255;
  localparam logic signed [CMD_W-1:0] RST_BOTTOM_INPUT  = -13'sd255;
  localparam logic [PCFG_W-1:0]       RST_MAX_PULSE     = 12'd2000;
  localparam logic [PCFG_W-1:0]       RST_NEUTRAL_PULSE = 12'd1500;
  localparam logic [PCFG_W-1:0]       RST_MIN_PULSE     = 12'd1000;

  typedef enum logic [1:0] {
    REGION_FWD     = 2'd0,
    REGION_REV     = 2'd1,
    REGION_RAW     = 2'd2,
    REGION_NEUTRAL = 2'd3
  } region_e;

  // Fields that ride alongside the arithmetic to the last stage
  typedef struct packed {
    logic [PCFG_W-1:0]       base;     // pulse added after the division
    logic signed [DIFF_W-1:0] fixed;   // result when no division applies
    logic                    use_div;
    region_e                 region;
  } side_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic signed [DQ_W-1:0]   dq;
    logic signed [DIFF_W-1:0] span;
    side_t                   side;
  } prep_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic signed [DIFF_W-1:0] span;
    side_t                   side;
  } mul_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] num;   // dividend bits still to be consumed, MSB first
    logic [MAG_W-1:0] quo;
    logic [DEN_W-1:0] den;
    logic             neg;
    side_t            side;
  } div_t;

endpackage

// File: rtl/mpp_if.sv
// Stream interfaces for the motor power to pulse width core: power commands
// in, pulse widths out. Depends on mpp_pkg.
interface mpp_cmd_if import mpp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

interface mpp_res_if import mpp_pkg::*; #(
  parameter int unsigned PULSE_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [PULSE_BITS-1:0] pulse_width;
  logic [1:0]            region;

  modport source (output valid, output pulse_width, output region, input ready);
  modport sink   (input valid, input pulse_width, input region, output ready);
endinterface

// File: rtl/motor_power_to_pulse_width_core.sv
// Motor power to pulse width core: a pipeline from the command transfer to
// the result being offered; throughput one command per cycle while the output
// is not stalled, set by a restoring divider unrolled one quotient bit per stage.
// Each stage holds its item until the next stage is free, so bubbles close up
// under a stall. Reset clears all stage valid bits and loads the register
// defaults; payload registers are not reset. Depends on mpp_pkg and mpp_if.
module motor_power_to_pulse_width_core import mpp_pkg::*; #(
  parameter int unsigned PULSE_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mpp_cmd_if.sink           cmd_i,
  mpp_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // Stage map: 0 prepare, 1 multiply, 2 magnitudes, 3..MAG_W+2 divide,
  // MAG_W+3 sign, offset and saturate (output register).
  localparam int unsigned NSTG = MAG_W + 4;
  localparam logic [VAL_W-1:0] PULSE_MAX = VAL_W'((64'd1 << PULSE_BITS) - 64'd1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CMD_W-1:0] neutral_point_q, top_input_q, bottom_input_q;
  logic [PCFG_W-1:0]       dead_band_q, max_pulse_q, neutral_pulse_q, min_pulse_q;
  logic [IDX_W-1:0]        cfg_idx;
  logic                    cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neutral_point_q <= RST_NEUTRAL_POINT;
      dead_band_q     <= RST_DEAD_BAND;
      top_input_q     <= RST_TOP_INPUT;
      bottom_input_q  <= RST_BOTTOM_INPUT;
      max_pulse_q     <= RST_MAX_PULSE;
      neutral_pulse_q <= RST_NEUTRAL_PULSE;
      min_pulse_q     <= RST_MIN_PULSE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NEUTRAL_POINT: neutral_point_q <= pwdata[CMD_W-1:0];
        REG_DEAD_BAND:     dead_band_q     <= pwdata[PCFG_W-1:0];
        REG_TOP_INPUT:     top_input_q     <= pwdata[CMD_W-1:0];
        REG_BOTTOM_INPUT:  bottom_input_q  <= pwdata[CMD_W-1:0];
        REG_MAX_PULSE:     max_pulse_q     <= pwdata[PCFG_W-1:0];
        REG_NEUTRAL_PULSE: neutral_pulse_q <= pwdata[PCFG_W-1:0];
        REG_MIN_PULSE:     min_pulse_q     <= pwdata[PCFG_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Read back, signed registers sign extended to the bus
  always_comb begin
    unique case (cfg_idx)
      REG_NEUTRAL_POINT: prdata = DATA_W'(neutral_point_q);
      REG_DEAD_BAND:     prdata = DATA_W'(dead_band_q);
      REG_TOP_INPUT:     prdata = DATA_W'(top_input_q);
      REG_BOTTOM_INPUT:  prdata = DATA_W'(bottom_input_q);
      REG_MAX_PULSE:     prdata = DATA_W'(max_pulse_q);
      REG_NEUTRAL_PULSE: prdata = DATA_W'(neutral_pulse_q);
      REG_MIN_PULSE:     prdata = DATA_W'(min_pulse_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage advances when it is empty or its successor
  // advances, so an item moves into any free slot and nothing is overwritten.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] valid_q, valid_d, adv;

  assign adv[NSTG-1] = !valid_q[NSTG-1] || res_o.ready;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_adv
    assign adv[k] = !valid_q[k] || adv[k+1];
  end

  assign valid_d     = {valid_q[NSTG-2:0], cmd_i.valid};
  assign cmd_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int unsigned k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: classify the command and pick the map operands
  // ---------------------------------------------------------------------------
  prep_t prep_d, prep_q;

  always_comb begin
    logic signed [DIFF_W-1:0] pwr_x, np_x, top_x, bot_x, d, db;
    logic signed [DQ_W-1:0]   max_x, neu_x, min_x;
    logic                     fwd, rev, raw;
    pwr_x = DIFF_W'(cmd_i.power);
    np_x  = DIFF_W'(neutral_point_q);
    top_x = DIFF_W'(top_input_q);
    bot_x = DIFF_W'(bottom_input_q);
    max_x = $signed({1'b0, max_pulse_q});
    neu_x = $signed({1'b0, neutral_pulse_q});
    min_x = $signed({1'b0, min_pulse_q});
    db    = $signed({2'b00, dead_band_q});
    d     = pwr_x - np_x;
    fwd   = d > db;
    rev   = d < -db;
    raw   = pwr_x > top_x;

    prep_d.side.base = neutral_pulse_q;
    prep_d.side.fixed = $signed({2'b00, neutral_pulse_q});
    if (fwd) begin
      // forward: neutral_point..top_input onto neutral_pulse..min_pulse
      prep_d.diff        = d;
      prep_d.dq          = min_x - neu_x;
      prep_d.span        = top_x - np_x;
      prep_d.side.region = REGION_FWD;
    end else if (rev) begin
      // reverse: bottom_input..neutral_point onto max_pulse..neutral_pulse
      prep_d.diff        = pwr_x - bot_x;
      prep_d.dq          = neu_x - max_x;
      prep_d.span        = np_x - bot_x;
      prep_d.side.base   = max_pulse_q;
      prep_d.side.region = REGION_REV;
    end else begin
      prep_d.diff        = d;
      prep_d.dq          = '0;
      prep_d.span        = '0;
      prep_d.side.region = raw ? REGION_RAW : REGION_NEUTRAL;
      if (raw) begin
        prep_d.side.fixed = pwr_x;
      end
    end
    // zero span falls back to the neutral pulse held in fixed
    prep_d.side.use_div = (fwd || rev) && (prep_d.span != '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      prep_q <= prep_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: product of input offset and pulse span
  // ---------------------------------------------------------------------------
  mul_t                            mul_q;
  logic signed [DIFF_W+DQ_W-1:0]   prod_full;

  assign prod_full = prep_q.diff * prep_q.dq;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      mul_q.prod <= prod_full[PROD_W-1:0];
      mul_q.span <= prep_q.span;
      mul_q.side <= prep_q.side;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: magnitudes and quotient sign, seed of the divider
  // ---------------------------------------------------------------------------
  div_t                     div_q [MAG_W+1];
  logic signed [PROD_W-1:0] prod_neg;
  logic signed [DIFF_W-1:0] span_neg;

  assign prod_neg = -mul_q.prod;
  assign span_neg = -mul_q.span;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      div_q[0].rem  <= '0;
      div_q[0].quo  <= '0;
      div_q[0].num  <= mul_q.prod[PROD_W-1] ? prod_neg[MAG_W-1:0]
                                            : mul_q.prod[MAG_W-1:0];
      div_q[0].den  <= mul_q.span[DIFF_W-1] ? span_neg[DEN_W-1:0]
                                            : mul_q.span[DEN_W-1:0];
      div_q[0].neg  <= mul_q.prod[PROD_W-1] ^ mul_q.span[DIFF_W-1];
      div_q[0].side <= mul_q.side;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3..MAG_W+2: restoring division, one quotient bit per stage.
  // Magnitudes give a quotient truncated toward zero.
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < MAG_W; j++) begin : g_div
    div_t             stg_d;
    logic [REM_W-1:0] trial;

    always_comb begin
      stg_d = div_q[j];
      trial = {div_q[j].rem[REM_W-2:0], div_q[j].num[MAG_W-1]};
      stg_d.num = {div_q[j].num[MAG_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q[j].den}) begin
        stg_d.rem = trial - {1'b0, div_q[j].den};
        stg_d.quo = {div_q[j].quo[MAG_W-2:0], 1'b1};
      end else begin
        stg_d.rem = trial;
        stg_d.quo = {div_q[j].quo[MAG_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[3+j]) begin
        div_q[j+1] <= stg_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Last stage: apply sign, add the base pulse, saturate
  // ---------------------------------------------------------------------------
  div_t                    fin;
  logic signed [VAL_W-1:0] q_abs, q_sgn, val;
  logic [PULSE_BITS-1:0]   pw_d, pw_q;
  region_e                 region_q;

  assign fin   = div_q[MAG_W];
  assign q_abs = $signed({2'b00, fin.quo});
  assign q_sgn = fin.neg ? -q_abs : q_abs;

  always_comb begin
    if (fin.side.use_div) begin
      val = q_sgn + $signed(VAL_W'(fin.side.base));
    end else begin
      val = VAL_W'(fin.side.fixed);
    end
    priority if (val[VAL_W-1]) begin
      pw_d = '0;
    end else if (val > $signed(PULSE_MAX)) begin
      pw_d = PULSE_MAX[PULSE_BITS-1:0];
    end else begin
      pw_d = val[PULSE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NSTG-1]) begin
      pw_q     <= pw_d;
      region_q <= fin.side.region;
    end
  end

  assign res_o.valid       = valid_q[NSTG-1];
  assign res_o.pulse_width = pw_q;
  assign res_o.region      = region_q;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for motor_power_to_pulse_width_core: power commands
// with random flow control and register settings, each result checked in order.
// Depends on mpp_pkg, mpp_if and the core itself.
module testbench;
  import mpp_pkg::*;

  localparam int unsigned PULSE_BITS   = 12;
  localparam longint      PULSE_TOP    = (longint'(1) << PULSE_BITS) - 1;
  // Index with no register behind it; writes there must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic signed [CMD_W-1:0] CMD_MIN = {1'b1, {(CMD_W-1){1'b0}}};
  localparam logic signed [CMD_W-1:0] CMD_MAX = {1'b0, {(CMD_W-1){1'b1}}};
  localparam logic [PCFG_W-1:0]       PCFG_MAX = '1;
  localparam int unsigned DRAIN_CYCLES  = MAG_W + 16;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 125;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [PULSE_BITS-1:0] pulse_width;
    region_e               region;
  } pulse_result_t;

  typedef struct {
    logic signed [CMD_W-1:0] neutral_point;
    logic [PCFG_W-1:0]       dead_band;
    logic signed [CMD_W-1:0] top_input;
    logic signed [CMD_W-1:0] bottom_input;
    logic [PCFG_W-1:0]       max_pulse;
    logic [PCFG_W-1:0]       neutral_pulse;
    logic [PCFG_W-1:0]       min_pulse;
  } pulse_settings_t;

  // Holds a copy of the registers, predicts the pulse for every command taken
  // and matches results against the oldest prediction.
  class pulse_scoreboard;
    logic signed [CMD_W-1:0] neutral_point;
    logic [PCFG_W-1:0]       dead_band;
    logic signed [CMD_W-1:0] top_input;
    logic signed [CMD_W-1:0] bottom_input;
    logic [PCFG_W-1:0]       max_pulse;
    logic [PCFG_W-1:0]       neutral_pulse;
    logic [PCFG_W-1:0]       min_pulse;
    pulse_result_t           awaited[$];
    int unsigned             errors;

    function new();
      neutral_point = RST_NEUTRAL_POINT;
      dead_band     = RST_DEAD_BAND;
      top_input     = RST_TOP_INPUT;
      bottom_input  = RST_BOTTOM_INPUT;
      max_pulse     = RST_MAX_PULSE;
      neutral_pulse = RST_NEUTRAL_PULSE;
      min_pulse     = RST_MIN_PULSE;
      errors        = 0;
    endfunction

    function void write_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_NEUTRAL_POINT: neutral_point = value[CMD_W-1:0];
        REG_DEAD_BAND:     dead_band     = value[PCFG_W-1:0];
        REG_TOP_INPUT:     top_input     = value[CMD_W-1:0];
        REG_BOTTOM_INPUT:  bottom_input  = value[CMD_W-1:0];
        REG_MAX_PULSE:     max_pulse     = value[PCFG_W-1:0];
        REG_NEUTRAL_PULSE: neutral_pulse = value[PCFG_W-1:0];
        REG_MIN_PULSE:     min_pulse     = value[PCFG_W-1:0];
        default: ;
      endcase
    endfunction

    // Linear map of x from a..b onto p..q, division truncating toward zero
    function longint map_linear(longint x, longint a, longint b, longint p, longint q);
      longint span;
      span = b - a;
      if (span == 0) return longint'(neutral_pulse);
      return (x - a) * (q - p) / span + p;
    endfunction

    function void note_command(logic signed [CMD_W-1:0] power);
      longint        cmd, np, db, offset, pw;
      pulse_result_t res;
      cmd    = power;
      np     = neutral_point;
      db     = dead_band;
      offset = cmd - np;
      if (offset > db) begin
        pw = map_linear(cmd, np, top_input, neutral_pulse, min_pulse);
        res.region = REGION_FWD;
      end else if (offset < -db) begin
        pw = map_linear(cmd, bottom_input, np, max_pulse, neutral_pulse);
        res.region = REGION_REV;
      end else if (cmd > longint'(top_input)) begin
        pw = cmd;
        res.region = REGION_RAW;
      end else begin
        pw = neutral_pulse;
        res.region = REGION_NEUTRAL;
      end
      if (pw < 0) pw = 0;
      else if (pw > PULSE_TOP) pw = PULSE_TOP;
      res.pulse_width = pw[PULSE_BITS-1:0];
      awaited.push_back(res);
    endfunction

    function void check_result(logic [PULSE_BITS-1:0] pw, logic [1:0] rg);
      pulse_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with none awaited: pulse_width %0d region %0d",
                 $time, pw, rg);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (pw !== want.pulse_width) begin
        $display("%0t: pulse_width expected %0d, actual %0d", $time,
                 want.pulse_width, pw);
        errors++;
      end
      if (rg !== want.region) begin
        $display("%0t: region expected %0d, actual %0d", $time, want.region, rg);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  idle_mode_e  idle_mode;
  logic        hold_request;
  logic        hold_done;
  int unsigned hold_left;
  int unsigned cycle_count;

  pulse_scoreboard sb = new();

  mpp_cmd_if cmd_if ();
  mpp_res_if #(.PULSE_BITS(PULSE_BITS)) res_if ();

  motor_power_to_pulse_width_core #(
    .PULSE_BITS(PULSE_BITS)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cmd_i   (cmd_if.sink),
    .res_o   (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung pipeline: give up well beyond the slowest sane run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: drive ready at the falling edge. A single long hold-off, once
  // requested, starves the output so the pipeline backs up to the input.
  initial begin
    res_if.ready = 1'b0;
    hold_done    = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else begin
        case (idle_mode)
          IDLE_RECEIVER: res_if.ready = ($urandom_range(99) >= 73);
          IDLE_BOTH:     res_if.ready = ($urandom_range(99) >= 38);
          default:       res_if.ready = 1'b1;
        endcase
      end
    end
  end

  // Check every result transfer at the rising edge
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      sb.check_result(res_if.pulse_width, res_if.region);
  end

  // Number of idle cycles before the next command, by the current mode
  function automatic int unsigned sender_gap();
    int unsigned gap;
    int unsigned pct;
    gap = 0;
    case (idle_mode)
      IDLE_SENDER: pct = 73;
      IDLE_BOTH:   pct = 38;
      default:     pct = 0;
    endcase
    while (gap < 40 && $urandom_range(99) < pct) gap++;
    return gap;
  endfunction

  // Offer one command and hold it until transferred; return at the falling edge
  task automatic send_command(input logic signed [CMD_W-1:0] power);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      cmd_if.valid = 1'b0;
      cmd_if.power = CMD_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid = 1'b1;
    cmd_if.power = power;
    do @(posedge clk); while (!cmd_if.ready);
    sb.note_command(power);
    @(negedge clk);
  endtask

  // Drop valid after the last command of a burst; called at a falling edge
  task automatic end_burst();
    cmd_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Load a full register set once the block has nothing in flight
  task automatic apply_settings(input pulse_settings_t s);
    wait_drained();
    apb_write(REG_NEUTRAL_POINT, DATA_W'(s.neutral_point));
    apb_write(REG_DEAD_BAND,     DATA_W'(s.dead_band));
    apb_write(REG_TOP_INPUT,     DATA_W'(s.top_input));
    apb_write(REG_BOTTOM_INPUT,  DATA_W'(s.bottom_input));
    apb_write(REG_MAX_PULSE,     DATA_W'(s.max_pulse));
    apb_write(REG_NEUTRAL_PULSE, DATA_W'(s.neutral_pulse));
    apb_write(REG_MIN_PULSE,     DATA_W'(s.min_pulse));
  endtask

  function automatic logic signed [CMD_W-1:0] extreme_cmd();
    case ($urandom_range(3))
      0:       return CMD_MIN;
      1:       return CMD_MAX;
      2:       return '0;
      default: return CMD_W'($urandom);
    endcase
  endfunction

  function automatic logic [PCFG_W-1:0] extreme_pulse();
    case ($urandom_range(2))
      0:       return '0;
      1:       return PCFG_MAX;
      default: return PCFG_W'($urandom);
    endcase
  endfunction

  // Kind 0: ordered ranges near the default; 1: extremes; 2: anything goes
  function automatic pulse_settings_t random_settings(int unsigned kind);
    pulse_settings_t s;
    int              np;
    case (kind)
      0: begin
        np              = int'($urandom_range(200)) - 100;
        s.neutral_point = CMD_W'(np);
        s.dead_band     = PCFG_W'($urandom_range(60));
        s.top_input     = CMD_W'(np + int'($urandom_range(1000, 1)));
        s.bottom_input  = CMD_W'(np - int'($urandom_range(1000, 1)));
        s.max_pulse     = PCFG_W'($urandom_range(2500, 1500));
        s.neutral_pulse = PCFG_W'($urandom_range(1700, 1300));
        s.min_pulse     = PCFG_W'($urandom_range(1500, 500));
      end
      1: begin
        s.neutral_point = extreme_cmd();
        s.dead_band     = ($urandom_range(1)) ? PCFG_MAX : '0;
        s.top_input     = extreme_cmd();
        s.bottom_input  = extreme_cmd();
        s.max_pulse     = extreme_pulse();
        s.neutral_pulse = extreme_pulse();
        s.min_pulse     = extreme_pulse();
      end
      default: begin
        s.neutral_point = CMD_W'($urandom);
        s.dead_band     = PCFG_W'($urandom_range(PCFG_MAX) >> $urandom_range(11));
        s.top_input     = CMD_W'($urandom);
        s.bottom_input  = CMD_W'($urandom);
        s.max_pulse     = PCFG_W'($urandom);
        s.neutral_pulse = PCFG_W'($urandom);
        s.min_pulse     = PCFG_W'($urandom);
      end
    endcase
    return s;
  endfunction

  // Aim commands at the band edges and range ends as well as anywhere
  function automatic logic signed [CMD_W-1:0] pick_power();
    int np;
    int db;
    int jitter;
    np     = sb.neutral_point;
    db     = sb.dead_band;
    jitter = int'($urandom_range(6)) - 3;
    case ($urandom_range(9))
      4:       return CMD_W'(np + db + jitter);
      5:       return CMD_W'(np - db + jitter);
      6:       return CMD_W'(int'(sb.top_input) + jitter);
      7:       return CMD_W'(int'(sb.bottom_input) + jitter);
      8:       return CMD_W'(np + int'($urandom_range(40)) - 20);
      default: return CMD_W'($urandom);
    endcase
  endfunction

  initial begin
    pulse_settings_t s;
    cmd_if.valid = 1'b0;
    cmd_if.power = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_mode    = IDLE_NONE;
    hold_request = 1'b0;
    rst_n        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults: neutral, edges of the mapped span, extrapolation past it
    send_command('0);
    send_command(13'sd1);
    send_command(-13'sd1);
    send_command(13'sd255);
    send_command(13'sd256);
    send_command(CMD_MAX);
    send_command(-13'sd255);
    send_command(-13'sd256);
    send_command(CMD_MIN);
    end_burst();

    // Dead band wider than the gap to the top: raw pass-through inside the band,
    // band edges, reverse extrapolation that saturates high. Poke the spare index.
    s = '{neutral_point: 13'sd100, dead_band: 12'd50, top_input: 13'sd120,
          bottom_input: -13'sd300, max_pulse: 12'd2500, neutral_pulse: 12'd1400,
          min_pulse: 12'd600};
    apply_settings(s);
    apb_write(REG_SPARE, DATA_W'(32'h0000_0abc));
    send_command(13'sd140);
    send_command(13'sd160);
    send_command(13'sd100);
    send_command(13'sd40);
    send_command(13'sd150);
    send_command(13'sd49);
    send_command(CMD_MIN);
    end_burst();

    // Inverted range near the bottom: raw value below zero, and a forward map
    // that overshoots the top of the pulse range
    s = '{neutral_point: -13'sd4000, dead_band: 12'd200, top_input: CMD_MIN,
          bottom_input: CMD_MIN, max_pulse: 12'd0, neutral_pulse: PCFG_MAX,
          min_pulse: 12'd0};
    apply_settings(s);
    send_command(-13'sd4000);
    send_command(CMD_MIN);
    send_command(-13'sd3700);
    send_command(CMD_MAX);
    end_burst();

    // Zero span on both sides: neutral pulse with the map's own region code
    s = '{neutral_point: 13'sd500, dead_band: 12'd10, top_input: 13'sd500,
          bottom_input: 13'sd500, max_pulse: 12'd2000, neutral_pulse: 12'd77,
          min_pulse: 12'd1000};
    apply_settings(s);
    send_command(13'sd600);
    send_command(13'sd400);
    send_command(13'sd505);
    send_command(13'sd500);
    end_burst();

    // Random phases: new settings each time, flow-control mode rotating
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      s = random_settings(phase % 3);
      apply_settings(s);
      idle_mode = idle_mode_e'(phase % 4);
      // Starve the output while commands keep coming
      if (phase == 4) hold_request = 1'b1;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        // Pause the sender mid-phase until every result is back
        if (phase == 6 && i == PHASE_ITEMS / 2) begin
          end_burst();
          wait_drained();
        end
        send_command(pick_power());
      end
      end_burst();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
